/* src/pcpa_pkg.sv */
// Shared types, codes and defaults for the per-CPU page free-list allocator.
package pcpa_pkg;

  localparam int NUM_CPUS_DEF   = 8;
  localparam int NUM_PAGES_DEF  = 32768;
  localparam int PAGE_SHIFT_DEF = 12;

  localparam logic [0:0] CMD_ALLOC = 1'b0;
  localparam logic [0:0] CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OOM     = 2'd1;
  localparam logic [1:0] ST_BADADDR = 2'd2;

  localparam logic [0:0] CFG_LOWER = 1'b0;
  localparam logic [0:0] CFG_UPPER = 1'b1;

  localparam logic [31:0] LOWER_RST = 32'h8000_0000;
  localparam logic [31:0] UPPER_RST = 32'h8800_0000;

  typedef struct packed {
    logic [0:0]  cmd;
    logic [2:0]  requester;
    logic [31:0] page_addr;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] granted_addr;
    logic        stolen;
  } out_word_t;

endpackage

/* src/pcpa_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module pcpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/percpu_page_free_list_allocator.sv */
// Per-CPU LIFO free-list page allocator with stealing (top level).
// Each CPU owns a LIFO list of free pages: list heads sit in flip-flops, the
// per-page next links sit in one synchronous RAM of NUM_PAGES entries. A free
// checks the address, writes the old head into the page's link and makes the
// page the new head. An allocate picks the requester's head, or else the
// lowest-numbered other non-empty list, reads that page's link from the RAM,
// and in the POP state loads the registered link as the new head. An allocate
// that finds every list empty reports out of memory from the idle state.
// A new word is taken
// once the previous one has finished and the output register can take a result.
// Link RAM entries need no initialization: a link is always written when its
// page is pushed. Software frees every page once to fill the lists.
module percpu_page_free_list_allocator
  import pcpa_pkg::*;
#(
  parameter int NUM_CPUS   = NUM_CPUS_DEF,
  parameter int NUM_PAGES  = NUM_PAGES_DEF,
  parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int KW = 33 - PAGE_SHIFT;
  localparam logic [32:0] PMASK = 33'((64'd1 << PAGE_SHIFT) - 64'd1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_POP  = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0] lower_r, upper_r;
  logic [32:0] base_r, base_nxt;

  logic          head_v_r   [NUM_CPUS];
  logic [IW-1:0] head_idx_r [NUM_CPUS];

  logic [CW-1:0] pop_cpu_r, pop_cpu_nxt;
  logic [IW-1:0] pop_idx_r, pop_idx_nxt;
  logic          pop_stolen_r, pop_stolen_nxt;

  logic      out_valid_r;
  out_word_t out_data_r, out_data_nxt;
  logic      out_load;

  logic          out_free, accept;
  logic          req_ok, own_v;
  logic [CW-1:0] req_idx;
  logic          steal_found;
  logic [CW-1:0] steal_cpu;
  logic [32:0]   off;
  logic [KW-1:0] k_full;
  logic [IW-1:0] k;
  logic          free_ok;
  logic          ram_we, ram_re;
  logic [IW:0]   ram_wdata, ram_rdata;
  logic [IW-1:0] ram_raddr;
  logic [31:0]   gaddr;

  pcpa_ram #(
    .WIDTH (IW + 1),
    .DEPTH (NUM_PAGES)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (k),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_IDLE) && out_free);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // page numbering base: lower limit rounded up; bit 32 flags overflow
  always_comb begin
    base_nxt = (({1'b0, cfg_data}) + PMASK) & ~PMASK;
  end

  assign req_ok  = 32'(in_data.requester) < 32'(NUM_CPUS);
  assign req_idx = CW'(in_data.requester);
  assign own_v   = req_ok && head_v_r[req_idx];

  always_comb begin
    steal_found = 1'b0;
    steal_cpu   = '0;
    for (int c = NUM_CPUS - 1; c >= 0; c--) begin
      if (head_v_r[c] && !(req_ok && (CW'(c) == req_idx))) begin
        steal_found = 1'b1;
        steal_cpu   = CW'(c);
      end
    end
  end

  assign off     = {1'b0, in_data.page_addr} - base_r;
  assign k_full  = off[32:PAGE_SHIFT];
  assign k       = IW'(k_full);
  assign free_ok = req_ok
                && (in_data.page_addr[PAGE_SHIFT-1:0] == '0)
                && (in_data.page_addr >= lower_r)
                && (in_data.page_addr < upper_r)
                && ({1'b0, in_data.page_addr} >= base_r)
                && (34'(k_full) < 34'(NUM_PAGES));

  assign ram_we    = accept && (in_data.cmd == CMD_FREE) && free_ok;
  assign ram_wdata = {head_v_r[req_idx] && req_ok, head_idx_r[req_idx]};
  assign ram_re    = accept && (in_data.cmd == CMD_ALLOC) && (own_v || steal_found);
  assign ram_raddr = own_v ? head_idx_r[req_idx] : head_idx_r[steal_cpu];

  assign gaddr = base_r[31:0] + 32'({pop_idx_r, {PAGE_SHIFT{1'b0}}});

  always_comb begin
    state_nxt      = state_r;
    pop_cpu_nxt    = pop_cpu_r;
    pop_idx_nxt    = pop_idx_r;
    pop_stolen_nxt = pop_stolen_r;
    out_load       = 1'b0;
    out_data_nxt   = '{status: ST_OK, granted_addr: '0, stolen: 1'b0};
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.cmd == CMD_FREE) begin
            out_load            = 1'b1;
            out_data_nxt.status = free_ok ? ST_OK : ST_BADADDR;
          end else if (own_v || steal_found) begin
            state_nxt      = S_POP;
            pop_cpu_nxt    = own_v ? req_idx : steal_cpu;
            pop_idx_nxt    = ram_raddr;
            pop_stolen_nxt = !own_v;
          end else begin
            out_load            = 1'b1;
            out_data_nxt.status = ST_OOM;
          end
        end
      end
      S_POP: begin
        if (out_free) begin
          out_load                  = 1'b1;
          out_data_nxt.granted_addr = gaddr;
          out_data_nxt.stolen       = pop_stolen_r;
          state_nxt                 = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      lower_r     <= LOWER_RST;
      upper_r     <= UPPER_RST;
      base_r      <= {1'b0, LOWER_RST};
      for (int c = 0; c < NUM_CPUS; c++) begin
        head_v_r[c] <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LOWER: begin
            lower_r <= cfg_data;
            base_r  <= base_nxt;
          end
          CFG_UPPER: upper_r <= cfg_data;
          default: ;
        endcase
      end
      if (ram_we) begin
        head_v_r[req_idx] <= 1'b1;
      end else if ((state_r == S_POP) && out_free) begin
        head_v_r[pop_cpu_r] <= ram_rdata[IW];
      end
    end
  end

  always_ff @(posedge clk) begin
    pop_cpu_r    <= pop_cpu_nxt;
    pop_idx_r    <= pop_idx_nxt;
    pop_stolen_r <= pop_stolen_nxt;
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
    if (ram_we) begin
      head_idx_r[req_idx] <= k;
    end else if ((state_r == S_POP) && out_free) begin
      head_idx_r[pop_cpu_r] <= ram_rdata[IW-1:0];
    end
  end

endmodule

/* tb/tb_percpu_page_free_list_allocator.sv */
// Self-checking testbench for the per-CPU page free-list allocator.
`timescale 1ns / 1ps

module tb_percpu_page_free_list_allocator;
  import pcpa_pkg::*;

  localparam logic [32:0] PAGE_MASK = (33'd1 << PAGE_SHIFT_DEF) - 33'd1;
  localparam int PAGE_BYTES = 1 << PAGE_SHIFT_DEF;

  class page_list_board;
    logic [31:0] lower_lim;
    logic [31:0] upper_lim;
    bit          head_ok  [NUM_CPUS_DEF];
    logic [15:0] head_idx [NUM_CPUS_DEF];
    bit          link_ok  [NUM_PAGES_DEF];
    logic [15:0] link_idx [NUM_PAGES_DEF];
    out_word_t   expected_q [$];
    int          errors;

    function new();
      lower_lim = LOWER_RST;
      upper_lim = UPPER_RST;
      errors = 0;
      foreach (head_ok[c]) begin
        head_ok[c] = 1'b0;
        head_idx[c] = '0;
      end
      foreach (link_ok[p]) begin
        link_ok[p] = 1'b0;
        link_idx[p] = '0;
      end
    endfunction

    function logic [32:0] page_base();
      return ({1'b0, lower_lim} + PAGE_MASK) & ~PAGE_MASK;
    endfunction

    function void write_reg(logic [0:0] index, logic [31:0] value);
      if (index == CFG_LOWER) lower_lim = value;
      else if (index == CFG_UPPER) upper_lim = value;
    endfunction

    function bit pop_head(int cpu, output logic [15:0] idx);
      idx = '0;
      if (!head_ok[cpu]) return 1'b0;
      idx = head_idx[cpu];
      head_ok[cpu] = link_ok[idx];
      head_idx[cpu] = link_idx[idx];
      return 1'b1;
    endfunction

    function void note_request(in_word_t w);
      out_word_t   e;
      logic [32:0] base;
      logic [32:0] addr;
      logic [32:0] k;
      logic [15:0] idx;
      bit          got;
      int          c;
      e = '0;
      base = page_base();
      addr = {1'b0, w.page_addr};
      got = 1'b0;
      if (w.cmd == CMD_FREE) begin
        if (w.requester >= NUM_CPUS_DEF || (addr & PAGE_MASK) != 0 ||
            addr < {1'b0, lower_lim} || addr >= {1'b0, upper_lim} || addr < base) begin
          e.status = ST_BADADDR;
        end else begin
          k = (addr - base) >> PAGE_SHIFT_DEF;
          if (k >= NUM_PAGES_DEF) begin
            e.status = ST_BADADDR;
          end else begin
            link_ok[k] = head_ok[w.requester];
            link_idx[k] = head_idx[w.requester];
            head_ok[w.requester] = 1'b1;
            head_idx[w.requester] = k[15:0];
          end
        end
      end else begin
        if (w.requester < NUM_CPUS_DEF) got = pop_head(w.requester, idx);
        if (got) begin
          e.granted_addr = 32'(base + (33'(idx) << PAGE_SHIFT_DEF));
        end else begin
          for (c = 0; c < NUM_CPUS_DEF && !got; c++) begin
            if (c != w.requester) got = pop_head(c, idx);
          end
          if (got) begin
            e.granted_addr = 32'(base + (33'(idx) << PAGE_SHIFT_DEF));
            e.stolen = 1'b1;
          end else begin
            e.status = ST_OOM;
          end
        end
      end
      expected_q.push_back(e);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(out_word_t got);
      out_word_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result word %h", got));
      end else begin
        e = expected_q.pop_front();
        if (got.status !== e.status)
          report($sformatf("status %0d, want %0d", got.status, e.status));
        if (got.granted_addr !== e.granted_addr)
          report($sformatf("granted_addr %h, want %h", got.granted_addr, e.granted_addr));
        if (got.stolen !== e.stolen)
          report($sformatf("stolen %b, want %b", got.stolen, e.stolen));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_data;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = CFG_LOWER;
  logic [31:0] cfg_data = '0;

  int send_idle_pct = 8;
  int recv_stall_pct = 52;

  page_list_board board = new();

  logic [31:0] seg_lower [7] = '{32'h8000_0000, 32'h8000_0000, 32'h0000_0000,
                                 32'h1000_0801, 32'hFFFF_F001, 32'hFFFF_F000,
                                 32'h0000_0000};
  logic [31:0] seg_upper [7] = '{32'h8800_0000, 32'hFFFF_FFFF, 32'h0001_0000,
                                 32'h1040_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                                 32'hFFFF_FFFF};

  percpu_page_free_list_allocator uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) board.check_result(out_data);
  end

  task send_word(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.note_request(w);
  endtask

  task send_req(logic [0:0] cmd, logic [2:0] cpu, logic [31:0] addr);
    in_word_t w;
    w.cmd = cmd;
    w.requester = cpu;
    w.page_addr = addr;
    send_word(w);
  endtask

  task wait_quiet();
    in_valid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_limits(logic [31:0] lower, logic [31:0] upper);
    cfg_we <= 1'b1;
    cfg_index <= CFG_LOWER;
    cfg_data <= lower;
    @(posedge clk);
    board.write_reg(CFG_LOWER, lower);
    cfg_index <= CFG_UPPER;
    cfg_data <= upper;
    @(posedge clk);
    board.write_reg(CFG_UPPER, upper);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function in_word_t make_word();
    in_word_t    w;
    logic [32:0] base;
    longint      nwin;
    longint      k;
    int          s;
    w.cmd = ($urandom_range(99) < 45) ? CMD_ALLOC : CMD_FREE;
    w.requester = 3'($urandom_range(NUM_CPUS_DEF - 1));
    w.page_addr = $urandom;
    if (w.cmd == CMD_FREE) begin
      base = board.page_base();
      if (base >= {1'b0, board.upper_lim}) nwin = 0;
      else nwin = longint'((({1'b0, board.upper_lim} - base) + PAGE_MASK) >> PAGE_SHIFT_DEF);
      s = $urandom_range(99);
      if (s < 65 && nwin > 0) begin
        if (s < 5 && nwin > NUM_PAGES_DEF)
          k = longint'(NUM_PAGES_DEF) +
              longint'($urandom_range(32'(((nwin - NUM_PAGES_DEF) > 16 ? 16 :
                                            nwin - NUM_PAGES_DEF) - 1)));
        else if (s < 25)
          k = longint'($urandom_range(32'((nwin > NUM_PAGES_DEF ? NUM_PAGES_DEF : nwin) - 1)));
        else
          k = longint'($urandom_range(32'((nwin > 64 ? 64 : nwin) - 1)));
        w.page_addr = 32'(base + (33'(k) << PAGE_SHIFT_DEF));
      end else if (s < 80) begin
        if (w.page_addr[11:0] == 12'h000) w.page_addr[0] = 1'b1;
      end else if (s < 90) begin
        case ($urandom_range(3))
          0: w.page_addr = board.upper_lim & ~32'(PAGE_MASK);
          1: w.page_addr = board.upper_lim;
          2: w.page_addr = (board.lower_lim & ~32'(PAGE_MASK)) - PAGE_BYTES;
          default: w.page_addr = board.lower_lim & ~32'(PAGE_MASK);
        endcase
      end
    end
    return w;
  endfunction

  initial begin
    int item_no;
    int seg;
    int n;
    item_no = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_req(CMD_ALLOC, 3'd0, 32'h0000_0000);
    send_req(CMD_ALLOC, 3'd7, 32'hFFFF_FFFF);
    send_req(CMD_FREE,  3'd0, 32'h8000_0000);
    send_req(CMD_FREE,  3'd0, 32'h8000_1000);
    send_req(CMD_FREE,  3'd3, 32'h87FF_F000);
    send_req(CMD_FREE,  3'd1, 32'h8000_0800);
    send_req(CMD_FREE,  3'd1, 32'h7FFF_F000);
    send_req(CMD_FREE,  3'd1, 32'h8800_0000);
    send_req(CMD_FREE,  3'd1, 32'hFFFF_F000);
    send_req(CMD_FREE,  3'd1, 32'h0000_0000);
    send_req(CMD_FREE,  3'd1, 32'hFFFF_FFFF);
    send_req(CMD_ALLOC, 3'd0, 32'h0000_0000);
    send_req(CMD_ALLOC, 3'd5, 32'h0000_0000);
    send_req(CMD_ALLOC, 3'd5, 32'h0000_0000);
    send_req(CMD_ALLOC, 3'd2, 32'h0000_0000);
    // double free forms a self loop, refree on another list breaks it
    send_req(CMD_FREE,  3'd2, 32'h8000_2000);
    send_req(CMD_FREE,  3'd2, 32'h8000_2000);
    send_req(CMD_ALLOC, 3'd2, 32'h0000_0000);
    send_req(CMD_ALLOC, 3'd2, 32'h0000_0000);
    send_req(CMD_FREE,  3'd6, 32'h8000_2000);
    send_req(CMD_ALLOC, 3'd2, 32'h0000_0000);
    send_req(CMD_ALLOC, 3'd6, 32'h0000_0000);
    send_req(CMD_ALLOC, 3'd4, 32'h0000_0000);

    for (seg = 0; seg < 7; seg++) begin
      if (seg > 0) begin
        wait_quiet();
        write_limits(seg_lower[seg], seg_upper[seg]);
      end
      for (n = 0; n < 72; n++) begin
        if (item_no < 168) begin
          send_idle_pct = 8;
          recv_stall_pct = 52;
        end else if (item_no < 336) begin
          send_idle_pct = 52;
          recv_stall_pct = 8;
        end else begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        send_word(make_word());
        item_no++;
      end
    end

    wait_quiet();
    repeat (10) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb_percpu_page_free_list_allocator OK");
    end else begin
      $display("tb_percpu_page_free_list_allocator NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_percpu_page_free_list_allocator NOT OK");
    $finish;
  end

endmodule
